// ----- src/vcsd_pkg.sv -----
// vcsd_pkg: shared types and constants of the sound-log command stream decoder.
// No dependencies; every other file except vcsd_if takes names from here by scope.
package vcsd_pkg;

    // Width of the saturating sample-delay accumulator (17..32).
    localparam int DELAY_BITS = 32;

    // Depth of the operation queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Command bytes.
    localparam logic [7:0] CMD_SKIP    = 8'h4f;
    localparam logic [7:0] CMD_PSG     = 8'h50;
    localparam logic [7:0] CMD_YM      = 8'h51;
    localparam logic [7:0] CMD_WAIT16  = 8'h61;
    localparam logic [7:0] CMD_WAIT735 = 8'h62;
    localparam logic [7:0] CMD_WAIT882 = 8'h63;
    localparam logic [7:0] CMD_END     = 8'h66;
    localparam logic [3:0] CMD_WAITN   = 4'h7;

    // Link prefixes.
    localparam logic [7:0] LINK_PSG = 8'h40;
    localparam logic [7:0] LINK_YM  = 8'h80;

    localparam logic [15:0] NTSC_FRAME = 16'd735;
    localparam logic [15:0] PAL_FRAME  = 16'd882;

    // Result kinds.
    localparam logic [1:0] KIND_DELAY   = 2'd0;
    localparam logic [1:0] KIND_LINK    = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_WRITE,
        OP_END,
        OP_UNKNOWN
    } t_op_kind;

    // head: first link byte or unknown code; arg: delay amount or data byte.
    typedef struct packed {
        t_op_kind    kind;
        logic [7:0]  head;
        logic [15:0] arg;
    } t_op;

    typedef struct packed {
        logic full;
        logic head_valid;
    } t_q_stat;

endpackage

// ----- src/vcsd_if.sv -----
// vcsd_if: valid/ready channel interfaces for stream bytes and results.
// Depends on nothing.
interface vcsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface vcsd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] value;
    logic        last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

// ----- src/vcsd_front.sv -----
// vcsd_front: byte parser; turns stream bytes into queue operations.
// Depends on vcsd_pkg and vcsd_byte_if.
module vcsd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vcsd_byte_if.sink         i_in,
    input  vcsd_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output vcsd_pkg::t_op     o_op
);

    typedef enum logic [2:0] {
        PH_CMD,
        PH_SKIP,
        PH_PSG,
        PH_YM_ADDR,
        PH_YM_DATA,
        PH_WAIT_LO,
        PH_WAIT_HI
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_addr, n_addr;
    logic [7:0] r_wait_lo, n_wait_lo;
    logic       accept;
    logic [7:0] b;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.stream_byte;

    always_comb begin
        n_phase   = r_phase;
        n_addr    = r_addr;
        n_wait_lo = r_wait_lo;
        o_push    = 1'b0;
        o_op      = '{kind: vcsd_pkg::OP_ADD, head: 8'h00, arg: 16'h0000};
        if (accept) begin
            case (r_phase)
                PH_SKIP: begin
                    n_phase = PH_CMD;
                end
                PH_PSG: begin
                    n_phase = PH_CMD;
                    o_push  = 1'b1;
                    o_op    = '{kind: vcsd_pkg::OP_WRITE, head: vcsd_pkg::LINK_PSG,
                                arg: {8'h00, b}};
                end
                PH_YM_ADDR: begin
                    n_addr  = b;
                    n_phase = PH_YM_DATA;
                end
                PH_YM_DATA: begin
                    n_phase = PH_CMD;
                    o_push  = 1'b1;
                    o_op    = '{kind: vcsd_pkg::OP_WRITE,
                                head: vcsd_pkg::LINK_YM | r_addr, arg: {8'h00, b}};
                end
                PH_WAIT_LO: begin
                    n_wait_lo = b;
                    n_phase   = PH_WAIT_HI;
                end
                PH_WAIT_HI: begin
                    n_phase = PH_CMD;
                    o_push  = 1'b1;
                    o_op    = '{kind: vcsd_pkg::OP_ADD, head: 8'h00, arg: {b, r_wait_lo}};
                end
                default: begin
                    // command byte (also any stray phase code)
                    n_phase = PH_CMD;
                    if (b == vcsd_pkg::CMD_SKIP) begin
                        n_phase = PH_SKIP;
                    end else if (b == vcsd_pkg::CMD_PSG) begin
                        n_phase = PH_PSG;
                    end else if (b == vcsd_pkg::CMD_YM) begin
                        n_phase = PH_YM_ADDR;
                    end else if (b == vcsd_pkg::CMD_WAIT16) begin
                        n_phase = PH_WAIT_LO;
                    end else if (b == vcsd_pkg::CMD_WAIT735) begin
                        o_push = 1'b1;
                        o_op   = '{kind: vcsd_pkg::OP_ADD, head: 8'h00,
                                   arg: vcsd_pkg::NTSC_FRAME};
                    end else if (b == vcsd_pkg::CMD_WAIT882) begin
                        o_push = 1'b1;
                        o_op   = '{kind: vcsd_pkg::OP_ADD, head: 8'h00,
                                   arg: vcsd_pkg::PAL_FRAME};
                    end else if (b == vcsd_pkg::CMD_END) begin
                        o_push = 1'b1;
                        o_op   = '{kind: vcsd_pkg::OP_END, head: 8'h00, arg: 16'h0000};
                    end else if (b[7:4] == vcsd_pkg::CMD_WAITN) begin
                        o_push = 1'b1;
                        o_op   = '{kind: vcsd_pkg::OP_ADD, head: 8'h00,
                                   arg: {12'h000, b[3:0]} + 16'd1};
                    end else begin
                        o_push = 1'b1;
                        o_op   = '{kind: vcsd_pkg::OP_UNKNOWN, head: b, arg: 16'h0000};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_CMD;
            r_addr    <= 8'h00;
            r_wait_lo <= 8'h00;
        end else begin
            r_phase   <= n_phase;
            r_addr    <= n_addr;
            r_wait_lo <= n_wait_lo;
        end
    end

endmodule

// ----- src/vcsd_queue.sv -----
// vcsd_queue: small register FIFO of operations between front and back.
// Depends on vcsd_pkg.
module vcsd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  vcsd_pkg::t_op      i_op,
    input  logic               i_pop,
    output vcsd_pkg::t_op      o_head,
    output vcsd_pkg::t_q_stat  o_stat
);

    vcsd_pkg::t_op                  r_mem [vcsd_pkg::Q_DEPTH];
    logic [vcsd_pkg::Q_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [vcsd_pkg::Q_CNT_W-1:0]   r_count;
    logic                           do_push, do_pop;

    assign o_stat.full       = (r_count == vcsd_pkg::Q_CNT_W'(vcsd_pkg::Q_DEPTH));
    assign o_stat.head_valid = (r_count != '0);
    assign o_head            = r_mem[r_rd_ptr];
    assign do_push           = i_push && !o_stat.full;
    assign do_pop            = i_pop && o_stat.head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

// ----- src/vcsd_back.sv -----
// vcsd_back: executes queued operations, keeps the delay accumulator and
// drives the registered result channel. Depends on vcsd_pkg and vcsd_result_if.
module vcsd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vcsd_pkg::t_op     i_head,
    input  vcsd_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    vcsd_result_if.source     o_out
);

    typedef enum logic [1:0] {
        WS_DELAY,
        WS_ADDR,
        WS_DATA
    } t_wstep;

    t_wstep                          r_wstep, n_wstep;
    logic [vcsd_pkg::DELAY_BITS-1:0] r_delay, n_delay;
    logic                            r_valid, n_valid;
    logic [1:0]                      r_kind, n_kind;
    logic [31:0]                     r_value, n_value;
    logic                            r_last, n_last;
    logic                            slot_free;
    logic [vcsd_pkg::DELAY_BITS:0]   sum;

    assign o_out.valid = r_valid;
    assign o_out.kind  = r_kind;
    assign o_out.value = r_value;
    assign o_out.last  = r_last;

    assign slot_free = !r_valid || o_out.ready;
    assign sum = {1'b0, r_delay} + (vcsd_pkg::DELAY_BITS + 1)'(i_head.arg);

    always_comb begin
        n_wstep = r_wstep;
        n_delay = r_delay;
        n_valid = r_valid && !o_out.ready;
        n_kind  = r_kind;
        n_value = r_value;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (i_q_stat.head_valid) begin
            case (i_head.kind)
                vcsd_pkg::OP_ADD: begin
                    o_pop   = 1'b1;
                    n_delay = sum[vcsd_pkg::DELAY_BITS] ? '1
                                                        : sum[vcsd_pkg::DELAY_BITS-1:0];
                end
                vcsd_pkg::OP_END: begin
                    if (slot_free) begin
                        o_pop   = 1'b1;
                        n_valid = 1'b1;
                        n_kind  = vcsd_pkg::KIND_END;
                        n_value = 32'd0;
                        n_last  = 1'b1;
                    end
                end
                vcsd_pkg::OP_UNKNOWN: begin
                    if (slot_free) begin
                        o_pop   = 1'b1;
                        n_valid = 1'b1;
                        n_kind  = vcsd_pkg::KIND_UNKNOWN;
                        n_value = {24'h000000, i_head.head};
                        n_last  = 1'b1;
                    end
                end
                default: begin
                    // register write: optional delay, then prefix and data bytes
                    if (slot_free) begin
                        n_valid = 1'b1;
                        n_kind  = vcsd_pkg::KIND_LINK;
                        n_last  = 1'b0;
                        case (r_wstep)
                            WS_DELAY: begin
                                if (r_delay != '0) begin
                                    n_kind  = vcsd_pkg::KIND_DELAY;
                                    n_value = 32'(r_delay);
                                    n_delay = '0;
                                    n_wstep = WS_ADDR;
                                end else begin
                                    n_value = {24'h000000, i_head.head};
                                    n_wstep = WS_DATA;
                                end
                            end
                            WS_ADDR: begin
                                n_value = {24'h000000, i_head.head};
                                n_wstep = WS_DATA;
                            end
                            default: begin
                                n_value = {24'h000000, i_head.arg[7:0]};
                                n_last  = 1'b1;
                                n_wstep = WS_DELAY;
                                o_pop   = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wstep <= WS_DELAY;
            r_delay <= '0;
            r_valid <= 1'b0;
        end else begin
            r_wstep <= n_wstep;
            r_delay <= n_delay;
            r_valid <= n_valid;
        end
        r_kind  <= n_kind;
        r_value <= n_value;
        r_last  <= n_last;
    end

endmodule

// ----- src/vgm_command_stream_decoder_core.sv -----
// vgm_command_stream_decoder_core: top level of the sound-log command stream
// decoder; depends on vcsd_pkg, vcsd_if, vcsd_front, vcsd_queue and vcsd_back.
// The decoder takes one command-stream byte per transaction and returns
// results of kind delay (pending 44.1 kHz samples), link byte, end/loop
// marker or unknown command; the last result caused by a byte carries last=1.
// Wait commands (0x61 lo hi, 0x62, 0x63, 0x7n) only add to a saturating delay
// accumulator; the pending delay is flushed as one delay result just before
// the two link bytes of the next PSG (0x50) or YM (0x51) write.
// Rate: the front parser accepts a byte in every cycle in which the
// four-entry operation queue has room, so input bytes go in back to back.
// The back end retires a wait even while the result channel stalls and
// emits one result per cycle while the channel is ready, so a write gives
// two or three results and end/unknown give one; the back end's single
// output register sets the sustained rate, at most three results for two
// bytes on a write-heavy stream. A byte's first result passes through the
// queue entry and then the back end's output register. There is no clearing
// pass: the block takes bytes from the first cycle after reset.
module vgm_command_stream_decoder_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    vcsd_byte_if.sink      i_in,
    vcsd_result_if.source  o_out
);

    // front -> queue
    logic              push;
    vcsd_pkg::t_op     push_op;
    // queue <-> back
    logic              pop;
    vcsd_pkg::t_op     head_op;
    vcsd_pkg::t_q_stat q_stat;

    // Parser: phase, pending register address and low wait byte live here.
    vcsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_op     (push_op)
    );

    // Decouples byte intake from result emission.
    vcsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_head  (head_op),
        .o_stat  (q_stat)
    );

    // Executor: delay accumulator, write sequencing, output register.
    vcsd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_op),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

    // No result may appear in the cycle after reset.
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

    // A full queue must hold off the byte stream.
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !i_in.ready)
        else $error("byte accepted while queue full");

    // A flushed delay is never zero and is always followed by link bytes.
    a_delay_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == vcsd_pkg::KIND_DELAY)
            |-> (o_out.value != 32'd0 && !o_out.last))
        else $error("bad delay result");

    // The back end only pops when the queue has an entry.
    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_stat.head_valid)
        else $error("pop from empty queue");

endmodule

// ----- tb/vgm_command_stream_decoder_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench of the command stream decoder: byte transactions in, result transactions out,
// every result checked against an in-bench decoder. Depends on vcsd_pkg, vcsd_if and the core.
module vgm_command_stream_decoder_core_tb;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_SAT_WAITS = 8;

    // Parse phases of the in-bench decoder.
    typedef enum logic [2:0] {
        ST_CMD,
        ST_SKIP,
        ST_PSG,
        ST_YM_ADDR,
        ST_YM_DATA,
        ST_WAIT_LO,
        ST_WAIT_HI
    } t_parse_state;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] value;
        logic        last;
    } t_link_result;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic tx_valid = 1'b0;
    logic [7:0] tx_byte = 8'h00;
    logic rx_ready = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_sent    = 0;
    int errors        = 0;
    int cycles        = 0;

    // Decoder state mirrored in the bench.
    t_parse_state parse_state = ST_CMD;
    logic [7:0]   held_address = 8'h00;
    logic [7:0]   wait_lo      = 8'h00;
    logic [31:0]  delay_acc    = 32'd0;

    // Results still owed by the block, oldest first.
    t_link_result decoded_q[$];

    vcsd_byte_if   byte_ch ();
    vcsd_result_if res_ch ();

    assign byte_ch.valid       = tx_valid;
    assign byte_ch.stream_byte = tx_byte;
    assign res_ch.ready        = rx_ready;

    vgm_command_stream_decoder_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (res_ch)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Saturating add at the accumulator width.
    function automatic logic [31:0] add_samples(input logic [31:0] acc,
                                                input logic [31:0] amount);
        logic [63:0] sum;
        logic [63:0] ceiling;
        ceiling = (64'd1 << vcsd_pkg::DELAY_BITS) - 64'd1;
        sum = 64'(acc) + 64'(amount);
        if (sum > ceiling) sum = ceiling;
        return sum[31:0];
    endfunction

    // A write flushes any pending delay before its two link bytes.
    function automatic void queue_write(input logic [7:0] first, input logic [7:0] data);
        if (delay_acc != 32'd0) begin
            decoded_q.push_back('{vcsd_pkg::KIND_DELAY, delay_acc, 1'b0});
            delay_acc = 32'd0;
        end
        decoded_q.push_back('{vcsd_pkg::KIND_LINK, {24'd0, first}, 1'b0});
        decoded_q.push_back('{vcsd_pkg::KIND_LINK, {24'd0, data}, 1'b0});
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int start;
        start = decoded_q.size();
        case (parse_state)
            ST_SKIP: begin
                parse_state = ST_CMD;
            end
            ST_PSG: begin
                parse_state = ST_CMD;
                queue_write(vcsd_pkg::LINK_PSG, b);
            end
            ST_YM_ADDR: begin
                held_address = b;
                parse_state  = ST_YM_DATA;
            end
            ST_YM_DATA: begin
                parse_state = ST_CMD;
                queue_write(vcsd_pkg::LINK_YM | held_address, b);
            end
            ST_WAIT_LO: begin
                wait_lo     = b;
                parse_state = ST_WAIT_HI;
            end
            ST_WAIT_HI: begin
                parse_state = ST_CMD;
                delay_acc   = add_samples(delay_acc, {16'd0, b, wait_lo});
            end
            default: begin
                parse_state = ST_CMD;
                if (b == vcsd_pkg::CMD_SKIP) begin
                    parse_state = ST_SKIP;
                end else if (b == vcsd_pkg::CMD_PSG) begin
                    parse_state = ST_PSG;
                end else if (b == vcsd_pkg::CMD_YM) begin
                    parse_state = ST_YM_ADDR;
                end else if (b == vcsd_pkg::CMD_WAIT16) begin
                    parse_state = ST_WAIT_LO;
                end else if (b == vcsd_pkg::CMD_WAIT735) begin
                    delay_acc = add_samples(delay_acc, {16'd0, vcsd_pkg::NTSC_FRAME});
                end else if (b == vcsd_pkg::CMD_WAIT882) begin
                    delay_acc = add_samples(delay_acc, {16'd0, vcsd_pkg::PAL_FRAME});
                end else if (b == vcsd_pkg::CMD_END) begin
                    decoded_q.push_back('{vcsd_pkg::KIND_END, 32'd0, 1'b0});
                end else if (b[7:4] == vcsd_pkg::CMD_WAITN) begin
                    delay_acc = add_samples(delay_acc, {28'd0, b[3:0]} + 32'd1);
                end else begin
                    decoded_q.push_back('{vcsd_pkg::KIND_UNKNOWN, {24'd0, b}, 1'b0});
                end
            end
        endcase
        if (decoded_q.size() > start) decoded_q[decoded_q.size() - 1].last = 1'b1;
    endfunction

    // One byte transaction, with random idle cycles ahead of it.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            tx_valid <= 1'b0;
            @(posedge clk);
        end
        tx_valid <= 1'b1;
        tx_byte  <= b;
        do begin
            @(posedge clk);
        end while (!byte_ch.ready);
        decode_byte(b);
        bytes_sent++;
    endtask

    // Hold the stream until every owed result has come back.
    task automatic drain_results();
        tx_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: random stalls and the field-by-field check.
    always @(posedge clk) begin
        t_link_result want;
        if (rst_n && res_ch.valid && rx_ready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected result kind %0d value %0h", res_ch.kind, res_ch.value);
                errors++;
            end else begin
                want = decoded_q.pop_front();
                if (res_ch.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, res_ch.kind);
                    errors++;
                end
                if (res_ch.value !== want.value) begin
                    $error("value: expected %0h, got %0h", want.value, res_ch.value);
                    errors++;
                end
                if (res_ch.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, res_ch.last);
                    errors++;
                end
            end
        end
        rx_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Every command, byte extremes, skip swallowing an end code, a delay kept across
    // end and unknown codes, and writes with and without a pending delay.
    task automatic test_directed_commands();
        logic [7:0] seq[$];
        seq = '{vcsd_pkg::CMD_WAIT735, vcsd_pkg::CMD_WAIT882,
                {vcsd_pkg::CMD_WAITN, 4'h0}, {vcsd_pkg::CMD_WAITN, 4'hf},
                vcsd_pkg::CMD_PSG, 8'h00,
                vcsd_pkg::CMD_PSG, 8'hff,
                vcsd_pkg::CMD_WAIT16, 8'hff, 8'hff,
                vcsd_pkg::CMD_END,
                8'h00,
                8'hff,
                vcsd_pkg::CMD_YM, 8'h00, 8'hff,
                vcsd_pkg::CMD_WAIT16, 8'h00, 8'h00,
                vcsd_pkg::CMD_YM, 8'hff, 8'h00,
                vcsd_pkg::CMD_SKIP, vcsd_pkg::CMD_END};
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // Mostly well-formed commands with random operands; the rest raw noise.
    task automatic test_random_stream(input int n_bytes);
        int start;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                send_byte(vcsd_pkg::CMD_PSG);
                send_byte(8'($urandom_range(255)));
            end else if (pick < 45) begin
                send_byte(vcsd_pkg::CMD_YM);
                send_byte(8'($urandom_range(255)));
                send_byte(8'($urandom_range(255)));
            end else if (pick < 60) begin
                send_byte(vcsd_pkg::CMD_WAIT16);
                send_byte(8'($urandom_range(255)));
                if ($urandom_range(3) == 0) send_byte(8'($urandom_range(255)));
                else send_byte(8'($urandom_range(3)));
            end else if (pick < 72) begin
                case ($urandom_range(2))
                    0: send_byte(vcsd_pkg::CMD_WAIT735);
                    1: send_byte(vcsd_pkg::CMD_WAIT882);
                    default: send_byte({vcsd_pkg::CMD_WAITN, 4'($urandom_range(15))});
                endcase
            end else if (pick < 77) begin
                send_byte(vcsd_pkg::CMD_END);
            end else if (pick < 82) begin
                send_byte(vcsd_pkg::CMD_SKIP);
                send_byte(8'($urandom_range(255)));
            end else begin
                send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    // Pile up maximal 16-bit waits, enough to pin a narrow accumulator at its
    // ceiling and to carry well past 16 bits on a wide one, add a little more,
    // then flush it with a write.
    task automatic test_delay_saturation();
        int n_waits;
        n_waits = int'(((64'd1 << vcsd_pkg::DELAY_BITS) - 64'd1) / 64'd65535) + 2;
        if (n_waits > MAX_SAT_WAITS) n_waits = MAX_SAT_WAITS;
        for (int i = 0; i < n_waits; i++) begin
            send_byte(vcsd_pkg::CMD_WAIT16);
            send_byte(8'hff);
            send_byte(8'hff);
        end
        send_byte({vcsd_pkg::CMD_WAITN, 4'hf});
        send_byte(vcsd_pkg::CMD_PSG);
        send_byte(8'($urandom_range(255)));
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 79;
        test_directed_commands();
        test_random_stream(90);
        drain_results();

        send_idle_pct = 79;
        recv_idle_pct = 36;
        test_random_stream(90);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(90);
        test_delay_saturation();
        drain_results();

        if (errors == 0 && decoded_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
